[rtl/cpws_pkg.sv]
// Package for the charge PWM stepper with clock.
// Register index codes, fixed widths and constants; no dependencies.
package cpws_pkg;

  localparam int GAIN_W         = 16;
  localparam int SCALED_W       = 16;
  localparam int GAIN_FRAC_BITS = 10;
  localparam int DUTY_W         = 8;
  localparam int TICK_W         = 8;
  localparam int SEC_W          = 6;
  localparam int MIN_W          = 6;
  localparam int HOUR_W         = 8;
  localparam int RUNMIN_W       = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  localparam int DEF_TICKS_PER_SECOND = 61;
  localparam int DEF_SAMPLE_BITS      = 10;

  localparam logic [DUTY_W-1:0]   DUTY_MAX    = 8'd255;
  localparam logic [SEC_W-1:0]    SEC_PER_MIN = 6'd60;
  localparam logic [MIN_W-1:0]    MIN_PER_HR  = 6'd60;
  localparam logic [SCALED_W-1:0] SCALED_MAX  = 16'hFFFF;

  localparam logic [GAIN_W-1:0] VGAIN_RESET = 16'd20250;
  localparam logic [GAIN_W-1:0] CGAIN_RESET = 16'd3333;

  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_GAIN  = 3'd4;

endpackage

[rtl/charge_pwm_stepper_with_clock.sv]
// Top level of the charge PWM stepper with clock.
// Depends on cpws_pkg for widths, register codes and reset values.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one control tick per item:
//   the raw voltage and current samples. Each item yields exactly one
//   result item on the output channel (out_valid / out_stall) carrying the
//   new duty, both scaled samples and the running clock fields.
//   Path: an accepted item lands in the input register, is scaled,
//   compared and applied to the duty and clock state on the way into the
//   result register, from which it is shown on the output channel.
//   Throughput: one item per cycle unless out_stall holds the result; the path
//   between the two registers is one 16-bit by SAMPLE_BITS multiply, a saturation
//   and the compares. Config: cfg_we writes register cfg_index with cfg_data;
//   indexes beyond the register list are ignored. Write only while idle.
//   Reset (rst_n low, synchronous) clears both pipeline valids, the duty
//   and all clock counters, and loads the register reset values.
//   When out_stall is high the result holds; the input register still
//   takes one more item if it is empty, then in_stall rises until the result is taken.
module charge_pwm_stepper_with_clock #(
  parameter int TICKS_PER_SECOND = cpws_pkg::DEF_TICKS_PER_SECOND,
  parameter int SAMPLE_BITS      = cpws_pkg::DEF_SAMPLE_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cpws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cpws_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [SAMPLE_BITS-1:0]          in_voltage_raw,
  input  logic [SAMPLE_BITS-1:0]          in_current_raw,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [cpws_pkg::DUTY_W-1:0]     out_duty,
  output logic [cpws_pkg::SCALED_W-1:0]   out_voltage_scaled,
  output logic [cpws_pkg::SCALED_W-1:0]   out_current_scaled,
  output logic [cpws_pkg::SEC_W-1:0]      out_seconds,
  output logic [cpws_pkg::MIN_W-1:0]      out_minutes,
  output logic [cpws_pkg::HOUR_W-1:0]     out_hours,
  output logic [cpws_pkg::RUNMIN_W-1:0]   out_run_minutes
);
  import cpws_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + GAIN_W;
  localparam logic [TICK_W-1:0] TPS = TICK_W'(TICKS_PER_SECOND);

  logic                   en_r;
  logic [SCALED_W-1:0]    vlim_r, clim_r;
  logic [GAIN_W-1:0]      vgain_r, cgain_r;

  logic                   a_valid_r;
  logic [SAMPLE_BITS-1:0] a_vraw_r, a_craw_r;

  logic                   out_valid_r;
  logic [DUTY_W-1:0]      duty_r, duty_nxt;
  logic [TICK_W-1:0]      tick_r, tick_nxt;
  logic [SEC_W-1:0]       sec_r, sec_nxt;
  logic [MIN_W-1:0]       min_r, min_nxt;
  logic [HOUR_W-1:0]      hour_r, hour_nxt;
  logic [RUNMIN_W-1:0]    runmin_r, runmin_nxt;
  logic [SCALED_W-1:0]    vscl_r, cscl_r, vscl_nxt, cscl_nxt;

  logic                   b_load, adv;
  logic [PROD_W-1:0]      vprod, cprod;
  logic [31:0]            vwide, cwide;

  assign b_load   = !out_valid_r || !out_stall;
  assign adv      = a_valid_r && b_load;
  assign in_stall = a_valid_r && !b_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r    <= 1'b0;
      vlim_r  <= '0;
      clim_r  <= '0;
      vgain_r <= VGAIN_RESET;
      cgain_r <= CGAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHARGE_ENABLE: en_r    <= cfg_data[0];
        REG_VOLTAGE_LIMIT: vlim_r  <= cfg_data;
        REG_CURRENT_LIMIT: clim_r  <= cfg_data;
        REG_VOLTAGE_GAIN:  vgain_r <= cfg_data;
        REG_CURRENT_GAIN:  cgain_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (!in_stall) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_vraw_r <= in_voltage_raw;
      a_craw_r <= in_current_raw;
    end
  end

  always_comb begin
    vprod = PROD_W'(a_vraw_r) * PROD_W'(vgain_r);
    cprod = PROD_W'(a_craw_r) * PROD_W'(cgain_r);
    vwide = 32'(vprod >> GAIN_FRAC_BITS);
    cwide = 32'(cprod >> GAIN_FRAC_BITS);
    vscl_nxt = (vwide > 32'(SCALED_MAX)) ? SCALED_MAX : vwide[SCALED_W-1:0];
    cscl_nxt = (cwide > 32'(SCALED_MAX)) ? SCALED_MAX : cwide[SCALED_W-1:0];

    duty_nxt = duty_r;
    if (en_r) begin
      if (vscl_nxt < vlim_r && cscl_nxt < clim_r && duty_r < DUTY_MAX) begin
        duty_nxt = duty_r + 1'b1;
      end else if (duty_r != '0) begin
        duty_nxt = duty_r - 1'b1;
      end
    end

    tick_nxt   = tick_r + 1'b1;
    sec_nxt    = sec_r;
    min_nxt    = min_r;
    hour_nxt   = hour_r;
    runmin_nxt = runmin_r;
    if (tick_nxt >= TPS) begin
      tick_nxt = '0;
      sec_nxt  = sec_r + 1'b1;
      if (sec_nxt >= SEC_PER_MIN) begin
        sec_nxt    = '0;
        min_nxt    = min_r + 1'b1;
        runmin_nxt = runmin_r + 1'b1;
        if (min_nxt >= MIN_PER_HR) begin
          min_nxt  = '0;
          hour_nxt = hour_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      duty_r      <= '0;
      tick_r      <= '0;
      sec_r       <= '0;
      min_r       <= '0;
      hour_r      <= '0;
      runmin_r    <= '0;
    end else begin
      if (b_load) begin
        out_valid_r <= a_valid_r;
      end
      if (adv) begin
        duty_r   <= duty_nxt;
        tick_r   <= tick_nxt;
        sec_r    <= sec_nxt;
        min_r    <= min_nxt;
        hour_r   <= hour_nxt;
        runmin_r <= runmin_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vscl_r <= vscl_nxt;
      cscl_r <= cscl_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_duty           = duty_r;
  assign out_voltage_scaled = vscl_r;
  assign out_current_scaled = cscl_r;
  assign out_seconds        = sec_r;
  assign out_minutes        = min_r;
  assign out_hours          = hour_r;
  assign out_run_minutes    = runmin_r;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid_r && !a_valid_r)
    else $error("valid not cleared by reset");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(duty_r) && $stable(tick_r) && $stable(runmin_r))
    else $error("state changed without an item advancing");

  a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
    tick_r < TPS)
    else $error("prescaler out of range");

  a_clock_range: assert property (@(posedge clk) disable iff (!rst_n)
    sec_r < SEC_PER_MIN && min_r < MIN_PER_HR)
    else $error("seconds or minutes out of range");

endmodule

[tb/charge_pwm_stepper_with_clock_tb.sv]
// Self-checking testbench for charge_pwm_stepper_with_clock.
// It predicts the duty, the scaled samples and the clock fields of every tick and
// compares them with each result item. Depends on cpws_pkg and the top-level RTL.
module charge_pwm_stepper_with_clock_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cpws_pkg::*;

  localparam int SB             = DEF_SAMPLE_BITS;
  localparam int TPS            = DEF_TICKS_PER_SECOND;
  localparam int RAW_MAX        = (1 << SB) - 1;
  localparam logic [SB-1:0] RAW_TOP = SB'(RAW_MAX);
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [DUTY_W-1:0]   duty;
    logic [SCALED_W-1:0] v_scaled;
    logic [SCALED_W-1:0] c_scaled;
    logic [SEC_W-1:0]    sec;
    logic [MIN_W-1:0]    min;
    logic [HOUR_W-1:0]   hr;
    logic [RUNMIN_W-1:0] run_min;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [SB-1:0] in_voltage_raw;
  logic [SB-1:0] in_current_raw;
  logic out_valid;
  logic out_stall;
  logic [DUTY_W-1:0] out_duty;
  logic [SCALED_W-1:0] out_voltage_scaled;
  logic [SCALED_W-1:0] out_current_scaled;
  logic [SEC_W-1:0] out_seconds;
  logic [MIN_W-1:0] out_minutes;
  logic [HOUR_W-1:0] out_hours;
  logic [RUNMIN_W-1:0] out_run_minutes;

  // predictor copy of registers and state
  logic                charge_en   = 1'b0;
  logic [GAIN_W-1:0]   v_limit     = '0;
  logic [GAIN_W-1:0]   c_limit     = '0;
  logic [GAIN_W-1:0]   v_gain      = VGAIN_RESET;
  logic [GAIN_W-1:0]   c_gain      = CGAIN_RESET;
  logic [DUTY_W-1:0]   duty_level  = '0;
  logic [TICK_W-1:0]   tick_cnt    = '0;
  logic [SEC_W-1:0]    sec_cnt     = '0;
  logic [MIN_W-1:0]    min_cnt     = '0;
  logic [HOUR_W-1:0]   hr_cnt      = '0;
  logic [RUNMIN_W-1:0] run_min_cnt = '0;

  tick_result_t pending_results[$];

  int gap_pct         = 0;
  int stall_pct       = 0;
  int ticks_sent      = 0;
  int results_checked = 0;
  int reg_writes      = 0;
  int errors          = 0;
  int quiet_cycles    = 0;

  charge_pwm_stepper_with_clock #(
    .TICKS_PER_SECOND(TPS),
    .SAMPLE_BITS(SB)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_voltage_raw(in_voltage_raw),
    .in_current_raw(in_current_raw),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_duty(out_duty),
    .out_voltage_scaled(out_voltage_scaled),
    .out_current_scaled(out_current_scaled),
    .out_seconds(out_seconds),
    .out_minutes(out_minutes),
    .out_hours(out_hours),
    .out_run_minutes(out_run_minutes)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [SCALED_W-1:0] scale_sample(input logic [SB-1:0] raw,
                                                       input logic [GAIN_W-1:0] gain);
    logic [SB+GAIN_W-1:0] prod;
    prod = raw * gain;
    prod = prod >> GAIN_FRAC_BITS;
    if (prod > SCALED_MAX) return SCALED_MAX;
    return prod[SCALED_W-1:0];
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand16();
    return CFG_DATA_W'($urandom_range(0, 65535));
  endfunction

  task automatic step_charger(input logic [SB-1:0] vr, input logic [SB-1:0] cr);
    tick_result_t r;
    logic [SCALED_W-1:0] vs;
    logic [SCALED_W-1:0] cs;
    vs = scale_sample(vr, v_gain);
    cs = scale_sample(cr, c_gain);
    if (charge_en) begin
      if (vs < v_limit && cs < c_limit && duty_level < DUTY_MAX) begin
        duty_level = duty_level + 1'b1;
      end else if (duty_level > 0) begin
        duty_level = duty_level - 1'b1;
      end
    end
    tick_cnt = tick_cnt + 1'b1;
    if (tick_cnt >= TPS) begin
      tick_cnt = '0;
      sec_cnt  = sec_cnt + 1'b1;
      if (sec_cnt >= SEC_PER_MIN) begin
        sec_cnt     = '0;
        min_cnt     = min_cnt + 1'b1;
        run_min_cnt = run_min_cnt + 1'b1;
        if (min_cnt >= MIN_PER_HR) begin
          min_cnt = '0;
          hr_cnt  = hr_cnt + 1'b1;
        end
      end
    end
    r.duty     = duty_level;
    r.v_scaled = vs;
    r.c_scaled = cs;
    r.sec      = sec_cnt;
    r.min      = min_cnt;
    r.hr       = hr_cnt;
    r.run_min  = run_min_cnt;
    pending_results.push_back(r);
  endtask

  task automatic compare_field(input string name, input int unsigned want, input int unsigned got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) step_charger(in_voltage_raw, in_current_raw);
  end

  always @(posedge clk) begin
    tick_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        compare_field("duty", 32'(want.duty), 32'(out_duty));
        compare_field("voltage_scaled", 32'(want.v_scaled), 32'(out_voltage_scaled));
        compare_field("current_scaled", 32'(want.c_scaled), 32'(out_current_scaled));
        compare_field("seconds", 32'(want.sec), 32'(out_seconds));
        compare_field("minutes", 32'(want.min), 32'(out_minutes));
        compare_field("hours", 32'(want.hr), 32'(out_hours));
        compare_field("run_minutes", 32'(want.run_min), 32'(out_run_minutes));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && $urandom_range(1, 100) <= stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_tick(input logic [SB-1:0] vr, input logic [SB-1:0] cr);
    if ($urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_voltage_raw <= vr;
    in_current_raw <= cr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
  endtask

  // registers change only once every result is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_word(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    reg_writes++;
    case (idx)
      REG_CHARGE_ENABLE: charge_en = data[0];
      REG_VOLTAGE_LIMIT: v_limit   = data;
      REG_CURRENT_LIMIT: c_limit   = data;
      REG_VOLTAGE_GAIN:  v_gain    = data;
      REG_CURRENT_GAIN:  c_gain    = data;
      default: ;
    endcase
  endtask

  task automatic write_regs(input logic en, input logic [CFG_DATA_W-1:0] vl,
                            input logic [CFG_DATA_W-1:0] cl, input logic [CFG_DATA_W-1:0] vg,
                            input logic [CFG_DATA_W-1:0] cg);
    wait_idle();
    cfg_word(REG_CHARGE_ENABLE, {{(CFG_DATA_W-1){1'b0}}, en});
    cfg_word(REG_VOLTAGE_LIMIT, vl);
    cfg_word(REG_CURRENT_LIMIT, cl);
    cfg_word(REG_VOLTAGE_GAIN, vg);
    cfg_word(REG_CURRENT_GAIN, cg);
    cfg_we <= 1'b0;
  endtask

  task automatic test_register_defaults();
    gap_pct   = 30;
    stall_pct = 30;
    send_tick('0, '0);
    send_tick(RAW_TOP, RAW_TOP);
    send_tick(RAW_TOP, '0);
    send_tick('0, RAW_TOP);
    send_tick(10'h2AA, 10'h155);
  endtask

  // unity gain makes scaled == raw, so the limit compare is exact
  task automatic test_duty_limits();
    write_regs(1'b1, 16'd500, 16'd500, 16'd1024, 16'd1024);
    send_tick('0, '0);
    send_tick(10'd499, 10'd499);
    send_tick(10'd500, '0);
    send_tick('0, 10'd500);
    send_tick('0, '0);
    send_tick(RAW_TOP, RAW_TOP);
    send_tick(RAW_TOP, RAW_TOP);
  endtask

  task automatic test_gain_extremes();
    write_regs(1'b1, SCALED_MAX, SCALED_MAX, 16'd0, 16'hFFFF);
    send_tick(RAW_TOP, RAW_TOP);
    send_tick(10'd1, 10'd1);
    send_tick(10'd512, '0);
  endtask

  task automatic test_ignored_writes();
    wait_idle();
    for (int i = REG_CURRENT_GAIN + 1; i < (1 << CFG_IDX_W); i++) begin
      cfg_word(CFG_IDX_W'(i), 16'hFFFF);
    end
    cfg_word(REG_CHARGE_ENABLE, '0);
    cfg_we <= 1'b0;
    send_tick('0, '0);
    send_tick(RAW_TOP, RAW_TOP);
    send_tick('0, RAW_TOP);
  endtask

  task automatic run_phase(input int n, input logic en, input logic [CFG_DATA_W-1:0] vl,
                           input logic [CFG_DATA_W-1:0] cl, input logic [CFG_DATA_W-1:0] vg,
                           input logic [CFG_DATA_W-1:0] cg, input int raw_max);
    write_regs(en, vl, cl, vg, cg);
    repeat (n) send_tick(SB'($urandom_range(0, raw_max)), SB'($urandom_range(0, raw_max)));
  endtask

  task automatic test_random_traffic();
    // reset gains never reach the top limits: duty climbs to full and bounces
    gap_pct = 25; stall_pct = 25;
    run_phase(320, 1'b1, SCALED_MAX, SCALED_MAX, VGAIN_RESET, CGAIN_RESET, RAW_MAX);
    gap_pct = 40; stall_pct = 10;
    run_phase(250, 1'b1, rand16(), rand16(), rand16(), rand16(), RAW_MAX);
    gap_pct = 0; stall_pct = 0;
    run_phase(150, 1'b0, rand16(), rand16(), rand16(), rand16(), RAW_MAX);
    gap_pct = 10; stall_pct = 50;
    run_phase(300, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, RAW_MAX);
    gap_pct = 30; stall_pct = 30;
    run_phase(200, 1'b1, rand16(), rand16(), 16'hFFFF, 16'hFFFF, RAW_MAX);
    gap_pct = 20; stall_pct = 20;
    run_phase(200, 1'b1, CFG_DATA_W'($urandom_range(0, RAW_MAX)),
              CFG_DATA_W'($urandom_range(0, RAW_MAX)),
              16'd1024, 16'd1024, int'($urandom_range(64, RAW_MAX)));
  endtask

  task automatic test_quiet_tail();
    gap_pct = 0; stall_pct = 0;
    run_phase(130, 1'b1, rand16(), rand16(), rand16(), rand16(), RAW_MAX);
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    in_voltage_raw <= '0;
    in_current_raw <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_defaults();
    test_duty_limits();
    test_gain_extremes();
    test_ignored_writes();
    test_random_traffic();
    test_quiet_tail();
    wait_idle();

    $display("%0d ticks sent, %0d results checked, %0d register writes", ticks_sent,
             results_checked, reg_writes);
    $display("clock reached %0d min %0d s; final duty %0d", min_cnt, sec_cnt, duty_level);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
